FILE: design/dosf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dosf_pkg: shared types and constants for the drop-oldest sample FIFO
// Field widths, register map, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package dosf_pkg;

	// payload and counter widths
	localparam int CAP_W   = 13;
	localparam int SMP_W   = 16;
	localparam int CNT_W   = 32;
	localparam int BURST_W = 16;
	localparam int POP_W   = 7;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

	// operation codes
	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

endpackage

FILE: design/drop_oldest_sample_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drop_oldest_sample_fifo: overwriting ring-buffer FIFO of audio samples
// A full FIFO drops its oldest sample on each push and counts the drops.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. func selects a push
//   of sample_in or a pop of up to pop_max samples (clamped to MAX_POP).
//   Each result is shown for one cycle with done high; the receiver has no
//   backpressure and must take every result as it comes.
//   Push: the result appears in the cycle after the request; a push may be taken
//   every cycle. Pop: the first sample appears in the cycle after the request,
//   then one sample per cycle, the final one with last high. A pop of more than
//   one sample keeps busy high until its final sample is read, because the single
//   read port of the sample memory gives one sample per cycle. An empty pop gives
//   one result with sample_valid low and does not raise busy.
//   Every result also carries level, burst drop count, totals and peak level.
//   Reset empties the FIFO, clears all counters and sets capacity to 4096
//   (clamped to DEPTH); the sample memory itself is not cleared and needs no
//   clearing pass. A capacity write empties the FIFO and keeps totals and peak;
//   it is to be made only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module drop_oldest_sample_fifo
	import dosf_pkg::*;
#(
	parameter int DEPTH   = 4096,
	parameter int MAX_POP = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	// request channel
	input  logic                     start,
	output logic                     busy,
	input  logic                     func,
	input  logic signed [SMP_W-1:0]  sample_in,
	input  logic                     push_last,
	input  logic [POP_W-1:0]         pop_max,
	// result channel
	output logic                     done,
	output logic signed [SMP_W-1:0]  sample_out,
	output logic                     sample_valid,
	output logic                     last,
	output logic [BURST_W-1:0]       burst_dropped,
	output logic [CAP_W-1:0]         level,
	output logic [CNT_W-1:0]         pushed_total,
	output logic [CNT_W-1:0]         popped_total,
	output logic [CNT_W-1:0]         dropped_total,
	output logic [CAP_W-1:0]         peak_level
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 1;
	localparam logic [CAP_W-1:0] SLOTS_RST =
		(int'(CAP_RESET) > DEPTH) ? CAP_W'(DEPTH) : CAP_RESET;

	// sample memory
	logic signed [SMP_W-1:0] mem [DEPTH];
	logic signed [SMP_W-1:0] rd_data_q;

	// control and status registers
	state_t              state_q, state_d;
	logic [CAP_W-1:0]    capacity_q;
	logic [CAP_W-1:0]    slots_q;
	logic [AW-1:0]       head_q;
	logic [CAP_W-1:0]    fill_q;
	logic [BURST_W-1:0]  burst_q;
	logic                burst_clr_q;
	logic [CNT_W-1:0]    push_cnt_q;
	logic [CNT_W-1:0]    pop_cnt_q;
	logic [CNT_W-1:0]    drop_cnt_q;
	logic [CAP_W-1:0]    peak_q;
	logic [POP_W-1:0]    remain_q, remain_d;
	logic                res_vld_q;
	logic                smp_vld_q;
	logic                last_q;

	// combinational helpers
	logic                cfg_we;
	logic [CAP_W-1:0]    wcap;
	logic [CAP_W-1:0]    slots_w;
	logic                acc;
	logic                push_acc;
	logic                pop_acc;
	logic [POP_W-1:0]    want;
	logic [POP_W-1:0]    got;
	logic [POP_W-1:0]    cnt;
	logic                issue;
	logic [SW-1:0]       head_nxt;
	logic [AW-1:0]       head_inc;
	logic [SW-1:0]       tail_sum;
	logic [AW-1:0]       tail;
	logic                full;
	logic [CAP_W-1:0]    fill_push;
	logic [BURST_W-1:0]  burst_base;

	// configuration decode and capacity clamp
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_q) : '0;
	assign wcap   = pwdata[CAP_W-1:0];

	always_comb begin
		if (wcap == '0) begin
			slots_w = CAP_W'(1);
		end else if (int'(wcap) > DEPTH) begin
			slots_w = CAP_W'(DEPTH);
		end else begin
			slots_w = wcap;
		end
	end

	// request decode and pop size
	assign busy     = (state_q == ST_POP);
	assign acc      = start & ~busy;
	assign push_acc = acc & (func == FUNC_PUSH);
	assign pop_acc  = acc & (func == FUNC_POP);
	assign want     = (pop_max > POP_W'(MAX_POP)) ? POP_W'(MAX_POP) : pop_max;
	assign got      = (CAP_W'(want) < fill_q) ? want : POP_W'(fill_q);
	assign cnt      = busy ? remain_q : got;
	assign issue    = busy | (pop_acc & (got != '0));
	assign remain_d = cnt - POP_W'(1);

	// ring pointer arithmetic
	assign head_nxt  = SW'(head_q) + SW'(1);
	assign head_inc  = (head_nxt >= SW'(slots_q)) ? '0 : head_nxt[AW-1:0];
	assign tail_sum  = SW'(head_q) + SW'(fill_q);
	assign tail      = (tail_sum >= SW'(slots_q)) ? AW'(tail_sum - SW'(slots_q))
	                                              : tail_sum[AW-1:0];
	assign full      = (fill_q == slots_q);
	assign fill_push = full ? fill_q : fill_q + CAP_W'(1);
	assign burst_base = burst_clr_q ? '0 : burst_q;

	// pop sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_acc && (got > POP_W'(1))) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (remain_q == POP_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// FIFO state, counters and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			slots_q     <= SLOTS_RST;
			head_q      <= '0;
			fill_q      <= '0;
			burst_q     <= '0;
			burst_clr_q <= 1'b0;
			push_cnt_q  <= '0;
			pop_cnt_q   <= '0;
			drop_cnt_q  <= '0;
			peak_q      <= '0;
			remain_q    <= '0;
			res_vld_q   <= 1'b0;
			smp_vld_q   <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			res_vld_q   <= acc | busy;
			smp_vld_q   <= issue;
			last_q      <= push_acc | (pop_acc & (got == '0)) | (issue & (cnt == POP_W'(1)));
			burst_clr_q <= push_acc & push_last;
			burst_q     <= burst_base;
			if (issue) begin
				remain_q <= remain_d;
			end
			if (cfg_we) begin
				capacity_q  <= wcap;
				slots_q     <= slots_w;
				head_q      <= '0;
				fill_q      <= '0;
				burst_q     <= '0;
				burst_clr_q <= 1'b0;
			end else if (push_acc) begin
				// full: new sample takes the oldest slot
				if (full) begin
					head_q     <= head_inc;
					drop_cnt_q <= drop_cnt_q + CNT_W'(1);
					if (burst_base != '1) begin
						burst_q <= burst_base + BURST_W'(1);
					end
				end
				fill_q     <= fill_push;
				push_cnt_q <= push_cnt_q + CNT_W'(1);
				if (fill_push > peak_q) begin
					peak_q <= fill_push;
				end
			end else if (issue) begin
				head_q    <= head_inc;
				fill_q    <= fill_q - CAP_W'(1);
				pop_cnt_q <= pop_cnt_q + CNT_W'(1);
			end
		end
	end

	// sample memory: write at tail on push, read at head on pop
	always_ff @(posedge clk) begin
		if (push_acc) begin
			mem[tail] <= sample_in;
		end
		if (issue) begin
			rd_data_q <= mem[head_q];
		end
	end

	// result ports
	assign done          = res_vld_q;
	assign sample_out    = smp_vld_q ? rd_data_q : '0;
	assign sample_valid  = smp_vld_q;
	assign last          = last_q;
	assign burst_dropped = burst_q;
	assign level         = fill_q;
	assign pushed_total  = push_cnt_q;
	assign popped_total  = pop_cnt_q;
	assign dropped_total = drop_cnt_q;
	assign peak_level    = peak_q;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the drop-oldest sample FIFO
// Sends push and pop requests and capacity writes, keeps its own image of the
// FIFO to predict each result, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import dosf_pkg::*;

	localparam int FIFO_DEPTH = 4096;
	localparam int POP_LIMIT  = 64;
	localparam int BURST_MAX  = 65535;
	localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

	typedef struct packed {
		logic [SMP_W-1:0]   smp;
		logic               vld;
		logic               lst;
		logic [BURST_W-1:0] burst;
		logic [CAP_W-1:0]   level;
		logic [CNT_W-1:0]   pushed;
		logic [CNT_W-1:0]   popped;
		logic [CNT_W-1:0]   dropped;
		logic [CAP_W-1:0]   peak;
	} fifo_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_AW-1:0]       paddr;
	logic [APB_DW-1:0]       pwdata;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;
	logic                    start;
	logic                    busy;
	logic                    func;
	logic signed [SMP_W-1:0] sample_in;
	logic                    push_last;
	logic [POP_W-1:0]        pop_max;
	logic                    done;
	logic signed [SMP_W-1:0] sample_out;
	logic                    sample_valid;
	logic                    last;
	logic [BURST_W-1:0]      burst_dropped;
	logic [CAP_W-1:0]        level;
	logic [CNT_W-1:0]        pushed_total;
	logic [CNT_W-1:0]        popped_total;
	logic [CNT_W-1:0]        dropped_total;
	logic [CAP_W-1:0]        peak_level;

	// image of the FIFO state
	logic [SMP_W-1:0] img_mem [FIFO_DEPTH];
	int unsigned      img_head;
	int unsigned      img_fill;
	int unsigned      img_burst;
	int unsigned      img_pushed;
	int unsigned      img_popped;
	int unsigned      img_dropped;
	int unsigned      img_peak;
	int unsigned      img_cap;

	fifo_result_t awaited_results[$];
	int unsigned  fail_count;
	int unsigned  send_idle_pct;

	drop_oldest_sample_fifo #(
		.DEPTH   (FIFO_DEPTH),
		.MAX_POP (POP_LIMIT)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.sample_in     (sample_in),
		.push_last     (push_last),
		.pop_max       (pop_max),
		.done          (done),
		.sample_out    (sample_out),
		.sample_valid  (sample_valid),
		.last          (last),
		.burst_dropped (burst_dropped),
		.level         (level),
		.pushed_total  (pushed_total),
		.popped_total  (popped_total),
		.dropped_total (dropped_total),
		.peak_level    (peak_level)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#24_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fail_count++;
		$display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) report_mismatch(name, got, want);
	endtask

	// expected result from the current image state
	task automatic queue_result(logic [SMP_W-1:0] smp, logic vld, logic lst);
		fifo_result_t r;
		r.smp     = smp;
		r.vld     = vld;
		r.lst     = lst;
		r.burst   = img_burst[BURST_W-1:0];
		r.level   = img_fill[CAP_W-1:0];
		r.pushed  = img_pushed;
		r.popped  = img_popped;
		r.dropped = img_dropped;
		r.peak    = img_peak[CAP_W-1:0];
		awaited_results.push_back(r);
	endtask

	// apply one accepted request to the image and queue its results
	task automatic advance_fifo_image(logic f, logic [SMP_W-1:0] smp, logic plast,
			logic [POP_W-1:0] pmax);
		int unsigned slots;
		int unsigned tail;
		int unsigned want;
		int unsigned got;
		int unsigned k;
		slots = (img_cap == 0) ? 1 : (img_cap > FIFO_DEPTH) ? FIFO_DEPTH : img_cap;
		if (img_head >= slots) img_head = 0;
		if (img_fill > slots) img_fill = slots;
		if (f == FUNC_PUSH) begin
			tail = img_head + img_fill;
			if (tail >= slots) tail -= slots;
			if (img_fill == slots) begin
				// full: oldest slot is overwritten
				img_head = (img_head + 1 >= slots) ? 0 : img_head + 1;
				img_dropped++;
				if (img_burst < BURST_MAX) img_burst++;
			end else begin
				img_fill++;
			end
			img_mem[tail] = smp;
			img_pushed++;
			if (img_fill > img_peak) img_peak = img_fill;
			queue_result('0, 1'b0, 1'b1);
			if (plast) img_burst = 0;
		end else begin
			want = (pmax > POP_LIMIT) ? POP_LIMIT : pmax;
			got  = (want < img_fill) ? want : img_fill;
			if (got == 0) queue_result('0, 1'b0, 1'b1);
			for (k = 0; k < got; k++) begin
				smp = img_mem[img_head];
				img_head = (img_head + 1 >= slots) ? 0 : img_head + 1;
				img_fill--;
				img_popped++;
				queue_result(smp, 1'b1, k + 1 == got);
			end
		end
	endtask

	// one request: optional idle gap, then hold start until taken
	task automatic send_request(logic f, logic [SMP_W-1:0] smp, logic plast,
			logic [POP_W-1:0] pmax);
		if ($urandom_range(99) < send_idle_pct) begin
			repeat ($urandom_range(4, 1)) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start     <= 1'b1;
		func      <= f;
		sample_in <= smp;
		push_last <= plast;
		pop_max   <= pmax;
		@(posedge clk);
		while (busy) @(posedge clk);
		advance_fifo_image(f, smp, plast, pmax);
	endtask

	task automatic push_sample(logic [SMP_W-1:0] smp, logic plast);
		send_request(FUNC_PUSH, smp, plast, POP_W'($urandom_range(127)));
	endtask

	task automatic pop_samples(int unsigned pmax);
		send_request(FUNC_POP, SMP_W'($urandom_range(65535)), 1'($urandom_range(1)),
			POP_W'(pmax));
	endtask

	// stop sending and let every awaited result arrive
	task automatic wait_fifo_quiet();
		@(negedge clk);
		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity write over APB while idle, then read back
	task automatic write_capacity(logic [31:0] value);
		wait_fifo_quiet();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		img_cap   = value & 32'h1FFF;
		img_head  = 0;
		img_fill  = 0;
		img_burst = 0;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("capacity readback", prdata, img_cap);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		fifo_result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing awaited",
					32'($unsigned(sample_out)), 32'd0);
			end else begin
				want = awaited_results.pop_front();
				check_field("sample_out", 32'($unsigned(sample_out)), 32'(want.smp));
				check_field("sample_valid", 32'(sample_valid), 32'(want.vld));
				check_field("last", 32'(last), 32'(want.lst));
				check_field("burst_dropped", 32'(burst_dropped), 32'(want.burst));
				check_field("level", 32'(level), 32'(want.level));
				check_field("pushed_total", pushed_total, want.pushed);
				check_field("popped_total", popped_total, want.popped);
				check_field("dropped_total", dropped_total, want.dropped);
				check_field("peak_level", 32'(peak_level), 32'(want.peak));
			end
		end
	end

	// pops on an empty FIFO right after reset
	task automatic test_empty_pops();
		pop_samples(5);
		pop_samples(0);
		pop_samples(127);
	endtask

	// sample extremes come back in order; zero size and clamp on pop
	task automatic test_push_pop_order();
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'h5555, 1'b0);
		push_sample(16'hAAAA, 1'b1);
		pop_samples(0);
		pop_samples(2);
		pop_samples(127);
		pop_samples(1);
	endtask

	// full FIFO drops the oldest, burst count restarts after push_last
	task automatic test_overwrite_oldest();
		int unsigned k;
		write_capacity(4);
		for (k = 1; k <= 7; k++) push_sample(SMP_W'($urandom_range(65535)), k == 7);
		for (k = 1; k <= 2; k++) push_sample(SMP_W'($urandom_range(65535)), k == 2);
		pop_samples(64);
	endtask

	// capacity zero, above depth, full depth, and write clearing contents
	task automatic test_capacity_settings();
		int unsigned k;
		write_capacity(0);
		for (k = 1; k <= 3; k++) push_sample(SMP_W'($urandom_range(65535)), k == 3);
		pop_samples(3);
		write_capacity(8191);
		for (k = 1; k <= 8; k++) push_sample(SMP_W'($urandom_range(65535)), k == 8);
		pop_samples(64);
		pop_samples(64);
		write_capacity(2);
		push_sample(SMP_W'($urandom_range(65535)), 1'b1);
		write_capacity(4096);
		pop_samples(10);
		for (k = 1; k <= 3; k++) push_sample(SMP_W'($urandom_range(65535)), k == 3);
		pop_samples(3);
	endtask

	// pop sizes above the limit are clamped
	task automatic test_pop_clamp();
		int unsigned k;
		for (k = 1; k <= 70; k++) push_sample(SMP_W'($urandom_range(65535)), k == 70);
		pop_samples(100);
		pop_samples(127);
		pop_samples(64);
	endtask

	// burst drop count grows on a full FIFO, then clears on push_last
	task automatic test_burst_drops();
		int unsigned k;
		send_idle_pct = 0;
		write_capacity(1);
		for (k = 0; k < 10; k++) push_sample(SMP_W'($urandom_range(65535)), 1'b0);
		push_sample(SMP_W'($urandom_range(65535)), 1'b1);
		push_sample(SMP_W'($urandom_range(65535)), 1'b1);
	endtask

	// random bursts and pops, capacity changed halfway
	task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
			logic [31:0] cap_a, logic [31:0] cap_b);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		int unsigned pmax;
		int unsigned k;
		bit          switched;
		send_idle_pct = idle_pct;
		write_capacity(cap_a);
		sent     = 0;
		switched = 1'b0;
		while (sent < n_items) begin
			if (!switched && sent >= n_items / 2) begin
				write_capacity(cap_b);
				switched = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 50) begin
				// well-formed burst closed by push_last
				len = $urandom_range(12, 1);
				for (k = 1; k <= len; k++)
					push_sample(SMP_W'($urandom_range(65535)), k == len);
				sent += len;
			end else if (pick < 58) begin
				// stray push, burst may be left open
				push_sample(SMP_W'($urandom_range(65535)), 1'($urandom_range(1)));
				sent++;
			end else if (pick < 97) begin
				pick = $urandom_range(99);
				if (pick < 8)
					pmax = 0;
				else if (pick < 18)
					pmax = $urandom_range(127, 64);
				else
					pmax = $urandom_range(16, 1);
				pop_samples(pmax);
				sent++;
			end else begin
				wait_fifo_quiet();
			end
		end
	endtask

	// main sequence
	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		start         = 1'b0;
		func          = FUNC_PUSH;
		sample_in     = '0;
		push_last     = 1'b0;
		pop_max       = '0;
		fail_count    = 0;
		send_idle_pct = 10;
		img_head      = 0;
		img_fill      = 0;
		img_burst     = 0;
		img_pushed    = 0;
		img_popped    = 0;
		img_dropped   = 0;
		img_peak      = 0;
		img_cap       = 32'(CAP_RESET);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_pops();
		test_push_pop_order();
		test_overwrite_oldest();
		test_capacity_settings();
		test_pop_clamp();
		test_burst_drops();
		test_random_traffic(110, 7, 6, 1);
		test_random_traffic(110, 49, 3, 17);
		test_random_traffic(110, 0, 40, 2);

		wait_fifo_quiet();
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: files.f
design/dosf_pkg.sv
design/drop_oldest_sample_fifo.sv
test/tb_top.sv
